[design/fcrp_pkg.sv]
// Shared constants, types and helpers for the call/return profiler.
`timescale 1ns / 1ps

package fcrp_pkg;

	localparam int MAX_FUNCS = 256;
	localparam int IDX_W     = $clog2(MAX_FUNCS);
	localparam int CNT_W     = $clog2(MAX_FUNCS + 1);

	localparam logic [7:0]  CALL_OPCODE = 8'hE8;
	localparam logic [31:0] CALL_LENGTH = 32'd5;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_CALL = 2'd1;
	localparam logic [1:0] OP_RET  = 2'd2;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_DUP       = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_CALL_CNT  = 3'd3;
	localparam logic [2:0] ST_CALL_SKIP = 3'd4;
	localparam logic [2:0] ST_TGT_UNK   = 3'd5;
	localparam logic [2:0] ST_RET_CNT   = 3'd6;
	localparam logic [2:0] ST_RET_NONE  = 3'd7;

	localparam logic REG_TEXT_LOW  = 1'b0;
	localparam logic REG_TEXT_HIGH = 1'b1;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] calls;
		logic [15:0] returns;
		logic        multi;
	} entry_t;

	// Low 8 bits of a table index, zero-extended when the table is small.
	function automatic logic [7:0] to_index8(input logic [IDX_W-1:0] idx);
		logic [IDX_W+7:0] wide;
		wide = {8'b0, idx};
		return wide[7:0];
	endfunction

endpackage

[design/fcrp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fcrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/function_call_return_profiler_unit.sv]
// Top level of the function call/return profiler.
//
// Usage: drive op, addr, func_size, first_byte and displacement with start high;
// the item is taken at a clock edge where start is high and busy is low.
// busy stays high while the item is worked on. Each item gives exactly one
// result: done is high for one cycle with status, entry_index, target_addr,
// calls_seen, returns_seen and multi_return valid in that cycle. The receiver
// cannot stall; a result is gone after its cycle.
// Config: cfg_we writes cfg_data into text_low (index 0) or text_high (index 1)
// at the clock edge; write only while busy is low and no result is pending.
// Flow: one shared RAM read port walks the table one entry per cycle, so an
// item's walk covers at most used entries (used = filled entries, up to 256);
// a call or add item stops on its first match; an item skipped on opcode or
// range, or with the unused op code, goes from the prepare step straight to
// the final step, which raises done, with no table walk. A new item may be
// accepted in the cycle its predecessor's done is shown.
// Reset: arst_n clears the fill count, the config registers and the sequencer;
// table contents need no clearing since only filled entries are read.
`timescale 1ns / 1ps

module function_call_return_profiler_unit
	import fcrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] addr,
	input  logic [31:0] func_size,
	input  logic [7:0]  first_byte,
	input  logic [31:0] displacement,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  entry_index,
	output logic [31:0] target_addr,
	output logic [31:0] calls_seen,
	output logic [15:0] returns_seen,
	output logic        multi_return
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [31:0]      text_low_q, text_high_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] rd_q;
	logic             cmp_v_q;
	logic [IDX_W-1:0] cmp_idx_q;
	logic             found_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_q;
	logic             skip_q;
	logic [31:0]      skip_tgt_q;

	logic [1:0]  op_q;
	logic [31:0] addr_q, size_q, target_q;
	logic [7:0]  byte_q;

	logic        done_q;
	logic [2:0]  status_q;
	logic [7:0]  index_q;
	logic [31:0] tgt_q, calls_q;
	logic [15:0] rets_q;
	logic        multi_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	logic        issue;
	logic [31:0] key;
	logic        start_hit, contains, better;
	logic [31:0] calls_inc;
	logic [15:0] rets_inc;

	fcrp_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_FUNCS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign issue     = (state_q == S_SCAN) && (rd_q < used_q);
	assign key       = (op_q == OP_ADD) ? addr_q : target_q;
	assign start_hit = (ram_rdata.start == key);
	assign contains  = (addr_q >= ram_rdata.start) &&
	                   ((addr_q - ram_rdata.start) < ram_rdata.length);
	assign better    = !found_q || (ram_rdata.start < hit_q.start);
	assign calls_inc = (hit_q.calls == 32'hFFFF_FFFF) ? hit_q.calls : hit_q.calls + 32'd1;
	assign rets_inc  = (hit_q.returns == 16'hFFFF) ? hit_q.returns : hit_q.returns + 16'd1;

	// Table write-back happens only in the final step.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_idx_q;
		ram_wdata = hit_q;
		if (state_q == S_FIN && !skip_q) begin
			case (op_q)
				OP_ADD: begin
					ram_we    = !found_q && (used_q != CNT_W'(MAX_FUNCS));
					ram_waddr = used_q[IDX_W-1:0];
					ram_wdata = '{start: addr_q, length: size_q, calls: 32'd0,
					              returns: 16'd0, multi: 1'b0};
				end
				OP_CALL: begin
					ram_we          = found_q;
					ram_wdata.calls = calls_inc;
				end
				OP_RET: begin
					ram_we            = found_q;
					ram_wdata.returns = rets_inc;
					ram_wdata.multi   = hit_q.multi || (rets_inc > 16'd1);
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			text_low_q  <= '0;
			text_high_q <= '0;
			used_q      <= '0;
			rd_q        <= '0;
			cmp_v_q     <= 1'b0;
			found_q     <= 1'b0;
			skip_q      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_TEXT_LOW:  text_low_q  <= cfg_data;
					REG_TEXT_HIGH: text_high_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					rd_q    <= '0;
					cmp_v_q <= 1'b0;
					found_q <= 1'b0;
					skip_q  <= 1'b0;
					state_q <= S_SCAN;
					case (op_q)
						OP_ADD, OP_RET: ;
						OP_CALL: begin
							if (byte_q != CALL_OPCODE) begin
								skip_q     <= 1'b1;
								skip_tgt_q <= '0;
								state_q    <= S_FIN;
							end else if (!(target_q >= text_low_q && target_q < text_high_q)) begin
								skip_q     <= 1'b1;
								skip_tgt_q <= target_q;
								state_q    <= S_FIN;
							end
						end
						default: begin
							skip_q     <= 1'b1;
							skip_tgt_q <= '0;
							state_q    <= S_FIN;
						end
					endcase
				end
				S_SCAN: begin
					cmp_v_q <= issue;
					if (issue) begin
						rd_q      <= rd_q + CNT_W'(1);
						cmp_idx_q <= rd_q[IDX_W-1:0];
					end
					if (!issue && !cmp_v_q) begin
						state_q <= S_FIN;
					end
					if (cmp_v_q) begin
						if (op_q == OP_RET) begin
							if (contains && better) begin
								found_q   <= 1'b1;
								hit_idx_q <= cmp_idx_q;
								hit_q     <= ram_rdata;
							end
						end else if (start_hit) begin
							// First match ends the walk; drop the read in flight.
							found_q   <= 1'b1;
							hit_idx_q <= cmp_idx_q;
							hit_q     <= ram_rdata;
							cmp_v_q   <= 1'b0;
							state_q   <= S_FIN;
						end
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (op_q == OP_ADD && !found_q && used_q != CNT_W'(MAX_FUNCS)) begin
						used_q <= used_q + CNT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item capture and result register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q     <= op;
			addr_q   <= addr;
			size_q   <= func_size;
			byte_q   <= first_byte;
			target_q <= addr + displacement + CALL_LENGTH;
		end
		if (state_q == S_FIN) begin
			status_q <= ST_CALL_SKIP;
			index_q  <= '0;
			tgt_q    <= '0;
			calls_q  <= '0;
			rets_q   <= '0;
			multi_q  <= 1'b0;
			if (skip_q) begin
				tgt_q <= skip_tgt_q;
			end else begin
				case (op_q)
					OP_ADD: begin
						if (found_q) begin
							status_q <= ST_DUP;
						end else if (used_q == CNT_W'(MAX_FUNCS)) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_ADDED;
							index_q  <= to_index8(used_q[IDX_W-1:0]);
						end
					end
					OP_CALL: begin
						tgt_q <= target_q;
						if (found_q) begin
							status_q <= ST_CALL_CNT;
							index_q  <= to_index8(hit_idx_q);
							calls_q  <= calls_inc;
							rets_q   <= hit_q.returns;
							multi_q  <= hit_q.multi;
						end else begin
							status_q <= ST_TGT_UNK;
						end
					end
					OP_RET: begin
						if (found_q) begin
							status_q <= ST_RET_CNT;
							index_q  <= to_index8(hit_idx_q);
							calls_q  <= hit_q.calls;
							rets_q   <= rets_inc;
							multi_q  <= hit_q.multi || (rets_inc > 16'd1);
						end else begin
							status_q <= ST_RET_NONE;
						end
					end
					default: status_q <= ST_CALL_SKIP;
				endcase
			end
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign entry_index  = index_q;
	assign target_addr  = tgt_q;
	assign calls_seen   = calls_q;
	assign returns_seen = rets_q;
	assign multi_return = multi_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result shown without a finished item");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(MAX_FUNCS))
		else $error("fill count beyond table depth");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_DUP || status == ST_FULL || status == ST_RET_NONE)
		|-> calls_seen == 32'd0 && returns_seen == 16'd0 && !multi_return &&
		    entry_index == 8'd0)
		else $error("non-entry result carries entry data");

endmodule

[tb/tb_function_call_return_profiler_unit.sv]
// Self-checking testbench for the function call/return profiler unit.
`timescale 1ns / 1ps

module tb_function_call_return_profiler_unit;
	import fcrp_pkg::*;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam logic [31:0] REGION_LO    = 32'h0040_0000;
	localparam int unsigned REGION_SPAN  = 32'h0010_0000;
	localparam int          CYCLE_LIMIT  = 3_000_000;
	localparam int          RET_BURST    = 16;
	localparam int          PHASE_ITEMS  = 230;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] addr;
		logic [31:0] fsize;
		logic [7:0]  opbyte;
		logic [31:0] disp;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  index;
		logic [31:0] target;
		logic [31:0] calls;
		logic [15:0] returns;
		logic        multi;
	} outcome_t;

	// Mirror of the function table plus the queue of outcomes still owed by the unit.
	class call_profile_tracker;
		logic [31:0] text_low;
		logic [31:0] text_high;
		entry_t      funcs[MAX_FUNCS];
		int          used;
		outcome_t    pending[$];
		int          errors;

		function new();
			text_low  = '0;
			text_high = '0;
			used      = 0;
			errors    = 0;
		endfunction

		function void set_reg(input logic idx, input logic [31:0] value);
			if (idx == REG_TEXT_LOW)
				text_low = value;
			else
				text_high = value;
		endfunction

		function void note_item(input cmd_t c);
			outcome_t    o;
			logic [31:0] tgt;
			int          i;
			int          hit_idx;
			bit          found;
			o = '0;
			found = 1'b0;
			hit_idx = 0;
			case (c.op)
				OP_ADD: begin
					for (i = 0; i < used; i++)
						if (funcs[i].start == c.addr)
							found = 1'b1;
					if (found) begin
						o.status = ST_DUP;
					end else if (used >= MAX_FUNCS) begin
						o.status = ST_FULL;
					end else begin
						funcs[used] = '{start: c.addr, length: c.fsize, calls: '0,
							returns: '0, multi: 1'b0};
						o.status = ST_ADDED;
						o.index  = 8'(used);
						used++;
					end
				end
				OP_CALL: begin
					if (c.opbyte != CALL_OPCODE) begin
						o.status = ST_CALL_SKIP;
					end else begin
						tgt = c.addr + c.disp + CALL_LENGTH;
						o.target = tgt;
						if (!(tgt >= text_low && tgt < text_high)) begin
							o.status = ST_CALL_SKIP;
						end else begin
							for (i = 0; i < used && !found; i++) begin
								if (funcs[i].start == tgt) begin
									found = 1'b1;
									hit_idx = i;
								end
							end
							if (!found) begin
								o.status = ST_TGT_UNK;
							end else begin
								if (funcs[hit_idx].calls != 32'hFFFF_FFFF)
									funcs[hit_idx].calls++;
								o.status  = ST_CALL_CNT;
								o.index   = 8'(hit_idx);
								o.calls   = funcs[hit_idx].calls;
								o.returns = funcs[hit_idx].returns;
								o.multi   = funcs[hit_idx].multi;
							end
						end
					end
				end
				OP_RET: begin
					// charge the lowest-addressed function that contains the address
					for (i = 0; i < used; i++) begin
						if (c.addr >= funcs[i].start &&
						    (c.addr - funcs[i].start) < funcs[i].length) begin
							if (!found || funcs[i].start < funcs[hit_idx].start)
								hit_idx = i;
							found = 1'b1;
						end
					end
					if (!found) begin
						o.status = ST_RET_NONE;
					end else begin
						if (funcs[hit_idx].returns != 16'hFFFF)
							funcs[hit_idx].returns++;
						if (funcs[hit_idx].returns > 16'd1)
							funcs[hit_idx].multi = 1'b1;
						o.status  = ST_RET_CNT;
						o.index   = 8'(hit_idx);
						o.calls   = funcs[hit_idx].calls;
						o.returns = funcs[hit_idx].returns;
						o.multi   = funcs[hit_idx].multi;
					end
				end
				default: o.status = ST_CALL_SKIP;
			endcase
			pending.push_back(o);
		endfunction

		function void report(input string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endfunction

		function void check_field(input string what, input logic [31:0] want,
				input logic [31:0] got);
			if (got !== want)
				report($sformatf("%s mismatch, expected %0h, actual %0h", what, want, got));
		endfunction

		function void check_result(input outcome_t got);
			outcome_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with no item outstanding, expected none, actual %0h",
					got));
			end else begin
				want = pending.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("entry_index", 32'(want.index), 32'(got.index));
				check_field("target_addr", want.target, got.target);
				check_field("calls_seen", want.calls, got.calls);
				check_field("returns_seen", 32'(want.returns), 32'(got.returns));
				check_field("multi_return", 32'(want.multi), 32'(got.multi));
			end
		endfunction

		function void flush_leftovers();
			while (pending.size() != 0)
				report($sformatf("missing result, expected %0h, actual none",
					pending.pop_front()));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = '0;
	logic [31:0] addr = '0;
	logic [31:0] func_size = '0;
	logic [7:0]  first_byte = '0;
	logic [31:0] displacement = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  entry_index;
	logic [31:0] target_addr;
	logic [31:0] calls_seen;
	logic [15:0] returns_seen;
	logic        multi_return;

	call_profile_tracker tracker;
	int no_idle_left = 0;
	int cycle_count = 0;

	function_call_return_profiler_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .addr(addr), .func_size(func_size), .first_byte(first_byte),
		.displacement(displacement), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .status(status), .entry_index(entry_index),
		.target_addr(target_addr), .calls_seen(calls_seen), .returns_seen(returns_seen),
		.multi_return(multi_return)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin : result_monitor
		outcome_t seen;
		if (arst_n && done) begin
			seen = '{status, entry_index, target_addr, calls_seen, returns_seen,
				multi_return};
			tracker.check_result(seen);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(input logic [1:0] o, input logic [31:0] a,
			input logic [31:0] sz, input logic [7:0] b, input logic [31:0] d);
		return '{op: o, addr: a, fsize: sz, opbyte: b, disp: d};
	endfunction

	function automatic logic [31:0] region_addr();
		return REGION_LO + $urandom_range(0, REGION_SPAN - 1);
	endfunction

	function automatic logic [31:0] known_start();
		return tracker.funcs[$urandom_range(0, tracker.used - 1)].start;
	endfunction

	// Mostly well-formed traffic: calls aimed at known starts, returns inside known bodies.
	function automatic cmd_t random_cmd();
		cmd_t        c;
		logic [31:0] tgt;
		int          r;
		int          pick;
		c = make_cmd(2'($urandom), $urandom, $urandom, 8'($urandom), $urandom);
		r = $urandom_range(0, 99);
		if (r < 20) begin
			c.op = OP_ADD;
			pick = $urandom_range(0, 99);
			c.addr = (pick < 15) ? known_start() : (pick < 88) ? region_addr() : $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				c.fsize = '0;
			else if (pick >= 10)
				c.fsize = $urandom_range(1, 4096);
		end else if (r < 60) begin
			c.op = OP_CALL;
			if ($urandom_range(0, 99) < 80)
				c.addr = region_addr();
			pick = $urandom_range(0, 99);
			tgt = (pick < 70) ? known_start() : (pick < 85) ? region_addr() : $urandom;
			c.disp = tgt - c.addr - CALL_LENGTH;
			if ($urandom_range(0, 99) < 85)
				c.opbyte = CALL_OPCODE;
		end else if (r < 92) begin
			c.op = OP_RET;
			pick = $urandom_range(0, tracker.used - 1);
			if ($urandom_range(0, 99) < 75) begin
				c.addr = tracker.funcs[pick].start;
				if (tracker.funcs[pick].length != 0)
					c.addr += $urandom % tracker.funcs[pick].length;
			end else if ($urandom_range(0, 1) == 0) begin
				c.addr = region_addr();
			end
		end else begin
			c.op = OP_UNUSED;
		end
		return c;
	endfunction

	task automatic run_item(input cmd_t c);
		int gap;
		int r;
		gap = 0;
		if (no_idle_left > 0) begin
			no_idle_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3)
				no_idle_left = $urandom_range(20, 80);
			else if (r >= 40 && r < 85)
				gap = $urandom_range(1, 3);
			else if (r >= 85 && r < 97)
				gap = $urandom_range(4, 20);
			else if (r >= 97)
				gap = $urandom_range(30, 300);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		op           <= c.op;
		addr         <= c.addr;
		func_size    <= c.fsize;
		first_byte   <= c.opbyte;
		displacement <= c.disp;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_item(c);
	endtask

	// Drop start and wait for every outstanding result before touching the registers.
	task automatic drain();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (tracker.pending.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		tracker.flush_leftovers();
		repeat (8) @(posedge clk);
	endtask

	task automatic set_section(input logic [31:0] lo, input logic [31:0] hi);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_TEXT_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_TEXT_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(REG_TEXT_LOW, lo);
		tracker.set_reg(REG_TEXT_HIGH, hi);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			run_item(random_cmd());
	endtask

	initial begin
		logic [31:0] fresh;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Section registers are still empty after reset.
		run_item(make_cmd(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 32'h0));
		// Hammer the top function with returns, back to back, to raise its multi flag.
		no_idle_left = RET_BURST;
		repeat (RET_BURST)
			run_item(make_cmd(OP_RET, 32'hFFFF_FFFF, $urandom, 8'($urandom), $urandom));
		no_idle_left = 0;
		run_item(make_cmd(OP_RET, 32'hFFFF_FFFE, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_CALL, 32'h0, 32'h0, CALL_OPCODE, 32'h0));
		run_item(make_cmd(OP_CALL, 32'h0040_0000, 32'h0, 8'h00, 32'h10));
		run_item(make_cmd(OP_UNUSED, '1, '1, '1, '1));
		run_item(make_cmd(OP_ADD, 32'h0, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_ADD, 32'h0, 32'h5, 8'h0, 32'h0));
		run_item(make_cmd(OP_RET, 32'h0, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_ADD, 32'h1000, 32'h100, 8'h0, 32'h0));
		run_item(make_cmd(OP_ADD, 32'h1080, 32'h200, 8'h0, 32'h0));
		run_item(make_cmd(OP_RET, 32'h10A0, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_RET, 32'h10A0, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_RET, 32'h1100, 32'h0, 8'h0, 32'h0));
		run_item(make_cmd(OP_RET, 32'h1280, 32'h0, 8'h0, 32'h0));

		set_section(32'h0, 32'hFFFF_FFFF);
		run_item(make_cmd(OP_CALL, 32'h2000, 32'h0, CALL_OPCODE, 32'h1000 - 32'h2000 - 32'd5));
		run_item(make_cmd(OP_CALL, 32'hFFFF_FFFB, 32'h0, CALL_OPCODE, 32'h0));
		run_item(make_cmd(OP_CALL, 32'hFFFF_FFFA, 32'h0, CALL_OPCODE, 32'h0));
		run_item(make_cmd(OP_CALL, 32'h3000, 32'h0, CALL_OPCODE, 32'h10));
		run_item(make_cmd(OP_CALL, 32'h2000, 32'h0, 8'hFF, 32'h0));
		run_item(make_cmd(OP_CALL, 32'h1000, 32'h0, CALL_OPCODE, 32'h7B));

		set_section(REGION_LO, REGION_LO + REGION_SPAN);
		run_random(PHASE_ITEMS);
		set_section(32'h0, 32'hFFFF_FFFF);
		run_random(PHASE_ITEMS);
		set_section(32'hFFFF_FFFF, 32'h0);
		run_random(PHASE_ITEMS);
		set_section(REGION_LO + 32'h8_0000, REGION_LO + 32'h8_0000);
		run_random(PHASE_ITEMS);
		set_section(REGION_LO + 32'h4_0000, REGION_LO + 32'hC_0000);
		run_random(PHASE_ITEMS);

		// Fill the table, then hit it with adds that must bounce.
		while (tracker.used < MAX_FUNCS)
			run_item(make_cmd(OP_ADD, region_addr(), $urandom_range(1, 4096),
				8'($urandom), $urandom));
		repeat (3) begin
			fresh = region_addr();
			run_item(make_cmd(OP_ADD, fresh, $urandom, 8'($urandom), $urandom));
		end
		run_item(make_cmd(OP_ADD, known_start(), $urandom, 8'($urandom), $urandom));
		set_section($urandom_range(0, REGION_LO),
			$urandom_range(REGION_LO + REGION_SPAN, 32'hFFFF_FFFF));
		run_random(80);

		drain();
		repeat (300) @(posedge clk);
		if (tracker.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[function_call_return_profiler_unit.f]
design/fcrp_pkg.sv
design/fcrp_ram.sv
design/function_call_return_profiler_unit.sv
tb/tb_function_call_return_profiler_unit.sv
